// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define SIRNET_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sirnet assertion failed");

// next-cycle implication, disabled in reset
`define SIRNET_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sirnet assertion failed");

`else

`define SIRNET_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SIRNET_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/sirnet_pkg.sv =====
// ----------------------------------------------------------------------------
// sirnet_pkg
// Types and constants of the SIR network epidemic step unit.
// ----------------------------------------------------------------------------
package sirnet_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 12;
    localparam int DRAW_W = 16;
    localparam int PROB_W = 17;
    localparam int NCNT_W = 13;
    localparam int CNT_W  = 13;
    localparam int RND_W  = 16;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEED      = 2'd0,
        CMD_CONTACT   = 2'd1,
        CMD_RECOVER   = 2'd2,
        CMD_END_ROUND = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        NS_SUS  = 3'd0,
        NS_INF  = 3'd1,
        NS_REM  = 3'd2,
        NS_PINF = 3'd3,
        NS_PREM = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_INFECT  = 2'd0,
        REG_RECOVER = 2'd1,
        REG_NODES   = 2'd2,
        REG_LIMIT   = 2'd3
    } t_reg;

    typedef struct packed {
        logic [PROB_W-1:0] infect_prob;
        logic [PROB_W-1:0] recover_prob;
        logic [NCNT_W-1:0] node_count;
        logic [RND_W-1:0]  round_limit;
    } t_cfg;

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = NCNT_W'(1);

endpackage

// ===== hdl/sirnet_if.sv =====
// ----------------------------------------------------------------------------
// sirnet channel interfaces
// Command and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sirnet_cmd_if;
    import sirnet_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  spreader;
    logic [IDX_W-1:0]  contact;
    logic [DRAW_W-1:0] draw;

    modport source (output valid, output cmd, output spreader, output contact,
                    output draw, input ready);
    modport sink   (input valid, input cmd, input spreader, input contact,
                    input draw, output ready);
endinterface

interface sirnet_res_if;
    import sirnet_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] susceptible_count;
    logic [CNT_W-1:0] infected_count;
    logic [CNT_W-1:0] removed_count;
    logic [RND_W-1:0] round_number;
    logic             changed;
    logic             finished;

    modport source (output valid, output susceptible_count, output infected_count,
                    output removed_count, output round_number, output changed,
                    output finished, input ready);
    modport sink   (input valid, input susceptible_count, input infected_count,
                    input removed_count, input round_number, input changed,
                    input finished, output ready);
endinterface

// ===== hdl/sir_network_epidemic_step_unit.sv =====
// ----------------------------------------------------------------------------
// sir_network_epidemic_step_unit
// SIR epidemic on a graph: node status table plus S/I/R totals and rounds.
// ----------------------------------------------------------------------------
// Node status lives in one NODES x 3 synchronous RAM (two read ports, one
// write port, registered reads). After reset a clearing pass writes every
// entry susceptible, with no command word taken. Contact and recovery words
// read the RAM when taken, then decide and write back in ST_EXEC, which
// waits for a free output slot. Seed sweeps the whole RAM, clearing it and
// placing the seed node, if it is below the node count, as it goes. End of
// round is a read-modify-write sweep over all entries, skipped once the
// round limit is reached. One result word per command word; it sits in an
// output register, and the next command is taken while it waits there.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sir_network_epidemic_step_unit #(
    parameter int NODES     = 4096,
    parameter int PROB_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sirnet_pkg::APB_AW-1:0] paddr,
    input  logic [sirnet_pkg::APB_DW-1:0] pwdata,
    output logic [sirnet_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    sirnet_cmd_if.sink                    i_in,
    sirnet_res_if.source                  o_out
);
    import sirnet_pkg::*;

    localparam int          AW       = $clog2(NODES);
    localparam logic [32:0] PROB_ONE = 33'(1) << PROB_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLR,
        ST_CMT,
        ST_CMT_LAST,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] sus;
        logic [CNT_W-1:0] inf;
        logic [CNT_W-1:0] rem;
        logic [RND_W-1:0] rnd;
        logic             changed;
        logic             finished;
    } t_res;

    t_cfg cfg;

    sirnet_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // status RAM
    t_status mem [NODES];

    t_state r_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wb_idx;
    logic          r_wb_vld;

    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_u;
    logic [IDX_W-1:0] r_v;
    logic [DRAW_W-1:0] r_draw;
    logic             r_seed_ok;

    t_status r_rd_a;
    t_status r_rd_b;

    logic [CNT_W-1:0] r_sus;
    logic [CNT_W-1:0] r_inf;
    logic [CNT_W-1:0] r_rem;
    logic [RND_W-1:0] r_round;
    logic             r_chg;

    t_res r_out;
    logic r_out_valid;

    logic [CNT_W-1:0] n_sus;
    logic [CNT_W-1:0] n_inf;
    logic [CNT_W-1:0] n_rem;

    logic [NCNT_W-1:0] live_n;
    logic [32:0]       inf_sat;
    logic [32:0]       rec_sat;
    logic              in_acc;
    logic              slot_free;
    logic              out_load;
    logic              seed_ok_in;
    logic              u_ok;
    logic              v_ok;
    logic              hit_contact;
    logic              hit_recover;
    logic              rd_en_a;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     u_addr;
    logic [AW-1:0]     v_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_status           mem_wd;
    t_status           cmt_val;
    logic              cmt_pend;
    logic              cmt_wr;
    logic              post_state;

    // effective node count, clamped to 1..NODES
    always_comb begin
        if (cfg.node_count == '0) begin
            live_n = NCNT_W'(1);
        end else if (32'(cfg.node_count) > 32'(NODES)) begin
            live_n = NCNT_W'(NODES);
        end else begin
            live_n = cfg.node_count;
        end
    end

    assign inf_sat = (33'(cfg.infect_prob) > PROB_ONE) ? PROB_ONE : 33'(cfg.infect_prob);
    assign rec_sat = (33'(cfg.recover_prob) > PROB_ONE) ? PROB_ONE : 33'(cfg.recover_prob);

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign post_state = (r_state == ST_EXEC) || (r_state == ST_OUT);
    assign out_load   = slot_free && post_state;
    assign seed_ok_in = {1'b0, i_in.spreader} < live_n;

    assign u_addr = AW'(r_u);
    assign v_addr = AW'(r_v);
    assign u_ok   = {1'b0, r_u} < live_n;
    assign v_ok   = {1'b0, r_v} < live_n;

    assign hit_contact = (r_cmd == CMD_CONTACT) && u_ok && v_ok && (r_rd_a == NS_INF)
                         && (r_rd_b == NS_SUS) && (33'(r_draw) <= inf_sat);
    assign hit_recover = (r_cmd == CMD_RECOVER) && u_ok && (r_rd_a == NS_INF)
                         && (33'(r_draw) <= rec_sat);

    // read port A: spreader at accept, sweep index during commit
    assign rd_en_a   = in_acc || (r_state == ST_CMT);
    assign rd_addr_a = (r_state == ST_CMT) ? r_idx : AW'(i_in.spreader);

    always_comb begin
        cmt_pend = 1'b0;
        unique case (r_rd_a)
            NS_PINF: begin
                cmt_val  = NS_INF;
                cmt_pend = 1'b1;
            end
            NS_PREM: begin
                cmt_val  = NS_REM;
                cmt_pend = 1'b1;
            end
            default: cmt_val = r_rd_a;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = NS_SUS;
        unique case (r_state)
            ST_INIT: mem_we = 1'b1;
            ST_CLR: begin
                mem_we = 1'b1;
                if (r_seed_ok && (r_idx == u_addr)) begin
                    mem_wd = NS_INF;
                end
            end
            ST_EXEC: begin
                if (slot_free && hit_contact) begin
                    mem_we = 1'b1;
                    mem_wa = v_addr;
                    mem_wd = NS_PINF;
                end else if (slot_free && hit_recover) begin
                    mem_we = 1'b1;
                    mem_wa = u_addr;
                    mem_wd = NS_PREM;
                end
            end
            ST_CMT, ST_CMT_LAST: begin
                mem_we = r_wb_vld;
                mem_wa = r_wb_idx;
                mem_wd = cmt_val;
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign cmt_wr = mem_we && ((r_state == ST_CMT) || (r_state == ST_CMT_LAST));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en_a) begin
            r_rd_a <= mem[rd_addr_a];
        end
        if (in_acc) begin
            r_rd_b <= mem[AW'(i_in.contact)];
        end
    end

    // totals after a contact or recovery word
    always_comb begin
        n_sus = r_sus;
        n_inf = r_inf;
        n_rem = r_rem;
        if (hit_contact) begin
            n_inf = r_inf + CNT_W'(1);
            if (r_sus != '0) begin
                n_sus = r_sus - CNT_W'(1);
            end
        end else if (hit_recover) begin
            n_rem = r_rem + CNT_W'(1);
            if (r_inf != '0) begin
                n_inf = r_inf - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_wb_vld    <= 1'b0;
            r_seed_ok   <= 1'b0;
            r_sus       <= '0;
            r_inf       <= '0;
            r_rem       <= '0;
            r_round     <= '0;
            r_chg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !o_out.ready);
            unique case (r_state)
                ST_INIT: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd  <= t_cmd'(i_in.cmd);
                        r_u    <= i_in.spreader;
                        r_v    <= i_in.contact;
                        r_draw <= i_in.draw;
                        unique case (t_cmd'(i_in.cmd))
                            CMD_SEED: begin
                                r_sus     <= seed_ok_in ? CNT_W'(live_n - NCNT_W'(1))
                                                        : CNT_W'(live_n);
                                r_inf     <= seed_ok_in ? CNT_W'(1) : '0;
                                r_rem     <= '0;
                                r_round   <= '0;
                                r_chg     <= 1'b1;
                                r_seed_ok <= seed_ok_in;
                                r_idx     <= '0;
                                r_state   <= ST_CLR;
                            end
                            CMD_CONTACT, CMD_RECOVER: r_state <= ST_EXEC;
                            CMD_END_ROUND: begin
                                r_chg <= 1'b0;
                                if (r_round < cfg.round_limit) begin
                                    r_round  <= r_round + RND_W'(1);
                                    r_idx    <= '0;
                                    r_wb_vld <= 1'b0;
                                    r_state  <= ST_CMT;
                                end else begin
                                    r_state <= ST_OUT;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_EXEC: begin
                    if (slot_free) begin
                        r_sus             <= n_sus;
                        r_inf             <= n_inf;
                        r_rem             <= n_rem;
                        r_out.sus         <= n_sus;
                        r_out.inf         <= n_inf;
                        r_out.rem         <= n_rem;
                        r_out.rnd         <= r_round;
                        r_out.changed     <= hit_contact || hit_recover;
                        r_out.finished    <= r_round >= cfg.round_limit;
                        r_state           <= ST_IDLE;
                    end
                end
                ST_CLR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_CMT: begin
                    // read at r_idx, write back the entry read last cycle
                    r_wb_vld <= 1'b1;
                    r_wb_idx <= r_idx;
                    if (r_wb_vld && cmt_pend) begin
                        r_chg <= 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_CMT_LAST;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_CMT_LAST: begin
                    if (r_wb_vld && cmt_pend) begin
                        r_chg <= 1'b1;
                    end
                    r_wb_vld <= 1'b0;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (slot_free) begin
                        r_out.sus      <= r_sus;
                        r_out.inf      <= r_inf;
                        r_out.rem      <= r_rem;
                        r_out.rnd      <= r_round;
                        r_out.changed  <= r_chg;
                        r_out.finished <= r_round >= cfg.round_limit;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.susceptible_count = r_out.sus;
    assign o_out.infected_count    = r_out.inf;
    assign o_out.removed_count     = r_out.rem;
    assign o_out.round_number      = r_out.rnd;
    assign o_out.changed           = r_out.changed;
    assign o_out.finished          = r_out.finished;

    `SIRNET_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !mem_we)
    `SIRNET_ASSERT_IMP(a_commit_clean, i_clk, i_rst_n, cmt_wr, mem_wd != NS_PINF && mem_wd != NS_PREM)
    `SIRNET_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(r_out_valid), $past(post_state))
    `SIRNET_ASSERT_NXT(a_exec_posts, i_clk, i_rst_n, out_load, r_out_valid && r_state == ST_IDLE)

endmodule

// ===== hdl/sirnet_apb_regs.sv =====
// ----------------------------------------------------------------------------
// sirnet_apb_regs
// APB configuration registers: probabilities, node count and round limit.
// ----------------------------------------------------------------------------
module sirnet_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sirnet_pkg::APB_AW-1:0] paddr,
    input  logic [sirnet_pkg::APB_DW-1:0] pwdata,
    output logic [sirnet_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output sirnet_pkg::t_cfg            o_cfg
);
    import sirnet_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.infect_prob  <= '0;
            r_cfg.recover_prob <= '0;
            r_cfg.node_count   <= NODE_COUNT_RST;
            r_cfg.round_limit  <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_INFECT:  r_cfg.infect_prob  <= pwdata[PROB_W-1:0];
                REG_RECOVER: r_cfg.recover_prob <= pwdata[PROB_W-1:0];
                REG_NODES:   r_cfg.node_count   <= pwdata[NCNT_W-1:0];
                REG_LIMIT:   r_cfg.round_limit  <= pwdata[RND_W-1:0];
                default:     r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_INFECT:  prdata = APB_DW'(r_cfg.infect_prob);
            REG_RECOVER: prdata = APB_DW'(r_cfg.recover_prob);
            REG_NODES:   prdata = APB_DW'(r_cfg.node_count);
            REG_LIMIT:   prdata = APB_DW'(r_cfg.round_limit);
            default:     prdata = '0;
        endcase
    end

endmodule
